FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/sfr_pkg.sv
// shared widths, register codes, config bundle and helpers for the sphere test unit
// no dependencies
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int POS_W    = 21;                    // block and camera coordinate width, Q.8
  localparam int AXIS_W   = 16;                    // unit vector component, Q1.14
  localparam int BND_W    = 24;                    // near/far/margin/slope fields
  localparam int FRAC_SH  = 14;                    // fraction bits of the axis vectors
  localparam int RSQ_SH   = 36;                    // radius squared to Q.44
  localparam int LEN_SH   = 28;                    // |d|^2 to Q.44

  localparam int CAM_W    = 63;
  localparam int AXREG_W  = 48;
  localparam int RSQ_W    = 24;
  localparam int CFG_DW   = 64;
  localparam int CFG_AW   = 6;
  localparam int NUM_REGS = 8;
  localparam int IDX_LSB  = 3;                     // registers on 8-byte boundaries
  localparam int IDX_W    = 3;

  localparam int IN_TDATA_W  = ((3 * POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  // datapath widths
  localparam int OFS_W    = POS_W + 1;             // block minus camera
  localparam int PROD_W   = OFS_W + AXIS_W;        // one component product
  localparam int PROJ_W   = PROD_W + 2;            // sum of three products, Q.22
  localparam int DEPTH8_W = PROJ_W - FRAC_SH;      // floor of depth, Q.8
  localparam int SP_W     = DEPTH8_W + BND_W;      // depth8 * slope
  localparam int DIST_W   = SP_W + 1;              // cone half width
  localparam int WIDE_W   = DIST_W + 1;            // room for negated half width
  localparam int SQ_W     = 2 * OFS_W;             // one squared offset
  localparam int LEN_W    = SQ_W + 2;              // |d|^2
  localparam int HALF_W   = (PROJ_W + 1) / 2;      // split of |p_front| for squaring
  localparam int HI_W     = PROJ_W - HALF_W;
  localparam int CMP_W    = 2 * PROJ_W + 2;        // line test compare width

  localparam logic [AXREG_W-1:0] FRONT_RST = 48'h0000_0000_4000;
  localparam logic [AXREG_W-1:0] UP_RST    = 48'h0000_4000_0000;
  localparam logic [AXREG_W-1:0] RIGHT_RST = 48'h4000_0000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_CAMERA = 3'd0,
    REG_FRONT  = 3'd1,
    REG_UP     = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_DEPTH  = 3'd4,
    REG_VCONE  = 3'd5,
    REG_HCONE  = 3'd6,
    REG_RSQ    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CAM_W-1:0]   camera;
    logic [AXREG_W-1:0] front;
    logic [AXREG_W-1:0] up;
    logic [AXREG_W-1:0] right;
    logic [AXREG_W-1:0] depth;
    logic [AXREG_W-1:0] vcone;
    logic [AXREG_W-1:0] hcone;
    logic [RSQ_W-1:0]   rsq;
  } sfr_cfg_t;

  // camera coordinate idx; bits past the register read as zero
  function automatic logic signed [POS_W-1:0] cam_field(input logic [CAM_W-1:0] cam,
                                                        input int unsigned idx);
    logic [POS_W-1:0] f;
    f = '0;
    for (int unsigned b = 0; b < POS_W; b++) begin
      if (idx * POS_W + b < CAM_W) begin
        f[b] = cam[idx * POS_W + b];
      end
    end
    return $signed(f);
  endfunction

  // component idx of a packed axis vector
  function automatic logic signed [AXIS_W-1:0] axis_field(input logic [AXREG_W-1:0] ax,
                                                          input int unsigned idx);
    return $signed(ax[idx * AXIS_W +: AXIS_W]);
  endfunction

endpackage

FILE: hdl/sphere_frustum_and_ray_test_unit.sv
// top level: six-stage sphere frustum cull and camera line test
// depends on sfr_pkg and sfr_cfg
`timescale 1ns / 1ps

// Takes one block centre per beat and returns one beat with two flags:
// in_frustum (sphere passes depth, vertical and horizontal cone tests) and
// looked_at (the camera line, infinite both ways, meets the sphere). The
// datapath is a six-stage pipeline, the last stage being the output register,
// and one beat can enter every cycle unless the result side stalls. The stage
// registers only move when the output register is free or being drained, so
// back-pressure on the result side freezes the whole pipe and in_tready
// follows out_tready combinationally. The stages follow the multiplier chain:
// offset, axis products, projection sums, depth times slope together with the
// split square of the front projection, the final adds and the compares.
// Configuration must be written through the apb-style port while the unit is
// idle (not enforced); all registers are at byte address 8*index and read back.
module sphere_frustum_and_ray_test_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beats
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // block_x [20:0], block_y [41:21], block_z [62:42], zero pad [63]
  input  logic [sfr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // result beats
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // in_frustum [0], looked_at [1], zero pad [7:2]
  output logic [sfr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sfr_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [sfr_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [sfr_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int OFS_W    = sfr_pkg::OFS_W;
  localparam int PROD_W   = sfr_pkg::PROD_W;
  localparam int PROJ_W   = sfr_pkg::PROJ_W;
  localparam int DEPTH8_W = sfr_pkg::DEPTH8_W;
  localparam int SP_W     = sfr_pkg::SP_W;
  localparam int DIST_W   = sfr_pkg::DIST_W;
  localparam int WIDE_W   = sfr_pkg::WIDE_W;
  localparam int SQ_W     = sfr_pkg::SQ_W;
  localparam int LEN_W    = sfr_pkg::LEN_W;
  localparam int HALF_W   = sfr_pkg::HALF_W;
  localparam int HI_W     = sfr_pkg::HI_W;
  localparam int CMP_W    = sfr_pkg::CMP_W;
  localparam int BND_W    = sfr_pkg::BND_W;
  localparam int POS_W    = sfr_pkg::POS_W;

  sfr_pkg::sfr_cfg_t cfg;

  sfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // pipe moves when the output slot is empty or being taken
  logic advance;
  logic out_tvalid_r;
  logic [5:1] vld_r;
  logic [5:1] vld_nxt;

  assign advance   = !out_tvalid_r || out_tready;
  assign in_tready = advance;

  // ---------------- stage 1: offset from camera ----------------
  logic signed [OFS_W-1:0] d_nxt [3];
  logic signed [OFS_W-1:0] d_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = OFS_W'($signed(in_tdata[i * POS_W +: POS_W]))
               - OFS_W'(sfr_pkg::cam_field(cfg.camera, i));
    end
  end

  // ---------------- stage 2: axis products and squares ----------------
  // prod[j][i]: axis j (front, up, right), component i
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic        [SQ_W-1:0]   dsq_nxt  [3];
  logic        [SQ_W-1:0]   dsq_r    [3];
  logic        [OFS_W-1:0]  dmag     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[0][i] = PROD_W'(d_r[i]) * PROD_W'(sfr_pkg::axis_field(cfg.front, i));
      prod_nxt[1][i] = PROD_W'(d_r[i]) * PROD_W'(sfr_pkg::axis_field(cfg.up, i));
      prod_nxt[2][i] = PROD_W'(d_r[i]) * PROD_W'(sfr_pkg::axis_field(cfg.right, i));
      // negating the most negative value still gives its magnitude unsigned
      dmag[i]    = d_r[i][OFS_W-1] ? OFS_W'(-d_r[i]) : OFS_W'(d_r[i]);
      dsq_nxt[i] = SQ_W'(dmag[i]) * SQ_W'(dmag[i]);
    end
  end

  // ---------------- stage 3: projections and |d|^2 ----------------
  logic signed [PROJ_W-1:0] proj_nxt [3];
  logic signed [PROJ_W-1:0] proj_r   [3];
  logic        [LEN_W-1:0]  len3_nxt;
  logic        [LEN_W-1:0]  len3_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      proj_nxt[j] = PROJ_W'(prod_r[j][0]) + PROJ_W'(prod_r[j][1]) + PROJ_W'(prod_r[j][2]);
    end
    len3_nxt = LEN_W'(dsq_r[0]) + LEN_W'(dsq_r[1]) + LEN_W'(dsq_r[2]);
  end

  // ---------------- stage 4: depth test, depth8*slope, split square ----------------
  logic signed [PROJ_W-1:0]   pf;
  logic        [PROJ_W-1:0]   pf_mag;
  logic        [HALF_W-1:0]   pf_lo;
  logic        [HI_W-1:0]     pf_hi;
  logic signed [DEPTH8_W-1:0] depth8;
  logic signed [WIDE_W-1:0]   near22;
  logic signed [WIDE_W-1:0]   far22;
  logic signed [WIDE_W-1:0]   pf_w;

  logic                       depth_ok_nxt;
  logic                       depth_ok4_r;
  logic signed [SP_W-1:0]     su_nxt;
  logic signed [SP_W-1:0]     su_r;
  logic signed [SP_W-1:0]     sr_nxt;
  logic signed [SP_W-1:0]     sr_r;
  logic        [2*HI_W-1:0]   hh_nxt;
  logic        [2*HI_W-1:0]   hh_r;
  logic   [HI_W+HALF_W-1:0]   hl_nxt;
  logic   [HI_W+HALF_W-1:0]   hl_r;
  logic        [2*HALF_W-1:0] ll_nxt;
  logic        [2*HALF_W-1:0] ll_r;
  logic signed [PROJ_W-1:0]   pu4_r;
  logic signed [PROJ_W-1:0]   pr4_r;
  logic        [LEN_W-1:0]    len4_r;

  always_comb begin
    pf     = proj_r[0];
    pf_mag = pf[PROJ_W-1] ? PROJ_W'(-pf) : PROJ_W'(pf);
    pf_lo  = pf_mag[HALF_W-1:0];
    pf_hi  = pf_mag[PROJ_W-1:HALF_W];
    // arithmetic shift floors toward minus infinity
    depth8 = $signed(pf[PROJ_W-1:sfr_pkg::FRAC_SH]);

    near22 = WIDE_W'($signed(cfg.depth[BND_W-1:0])) <<< sfr_pkg::FRAC_SH;
    far22  = WIDE_W'($signed(cfg.depth[2*BND_W-1:BND_W])) <<< sfr_pkg::FRAC_SH;
    pf_w   = WIDE_W'(pf);
    depth_ok_nxt = (near22 <= pf_w) && (pf_w <= far22);

    su_nxt = SP_W'(depth8) * SP_W'($signed(cfg.vcone[2*BND_W-1:BND_W]));
    sr_nxt = SP_W'(depth8) * SP_W'($signed(cfg.hcone[2*BND_W-1:BND_W]));

    hh_nxt = (2*HI_W)'(pf_hi) * (2*HI_W)'(pf_hi);
    hl_nxt = (HI_W+HALF_W)'(pf_hi) * (HI_W+HALF_W)'(pf_lo);
    ll_nxt = (2*HALF_W)'(pf_lo) * (2*HALF_W)'(pf_lo);
  end

  // ---------------- stage 5: cone half widths, line test sums ----------------
  logic signed [DIST_W-1:0] dist_u_nxt;
  logic signed [DIST_W-1:0] dist_u_r;
  logic signed [DIST_W-1:0] dist_r_nxt;
  logic signed [DIST_W-1:0] dist_r_r;
  logic        [CMP_W-1:0]  lhs_nxt;
  logic        [CMP_W-1:0]  lhs_r;
  logic        [CMP_W-1:0]  rhs_nxt;
  logic        [CMP_W-1:0]  rhs_r;
  logic                     depth_ok5_r;
  logic signed [PROJ_W-1:0] pu5_r;
  logic signed [PROJ_W-1:0] pr5_r;

  always_comb begin
    dist_u_nxt = (DIST_W'($signed(cfg.vcone[BND_W-1:0])) <<< sfr_pkg::FRAC_SH)
               + DIST_W'(su_r);
    dist_r_nxt = (DIST_W'($signed(cfg.hcone[BND_W-1:0])) <<< sfr_pkg::FRAC_SH)
               + DIST_W'(sr_r);
    // p_front^2 rebuilt from the split products, plus radius^2 at Q.44
    lhs_nxt = (CMP_W'(hh_r) << (2 * HALF_W))
            + (CMP_W'(hl_r) << (HALF_W + 1))
            + CMP_W'(ll_r)
            + (CMP_W'(cfg.rsq) << sfr_pkg::RSQ_SH);
    rhs_nxt = CMP_W'(len4_r) << sfr_pkg::LEN_SH;
  end

  // ---------------- stage 6: compares into the output register ----------------
  logic                   in_frustum_nxt;
  logic                   looked_at_nxt;
  logic                   in_frustum_r;
  logic                   looked_at_r;
  logic                   side_u_ok;
  logic                   side_r_ok;
  logic signed [WIDE_W-1:0] du_w;
  logic signed [WIDE_W-1:0] dr_w;
  logic signed [WIDE_W-1:0] pu_w;
  logic signed [WIDE_W-1:0] pr_w;

  always_comb begin
    du_w = WIDE_W'(dist_u_r);
    dr_w = WIDE_W'(dist_r_r);
    pu_w = WIDE_W'(pu5_r);
    pr_w = WIDE_W'(pr5_r);
    // a negative half width can never pass
    side_u_ok = (-du_w <= pu_w) && (pu_w <= du_w);
    side_r_ok = (-dr_w <= pr_w) && (pr_w <= dr_w);
    in_frustum_nxt = depth_ok5_r && side_u_ok && side_r_ok;
    looked_at_nxt  = (lhs_r >= rhs_r);
  end

  // valid bits travel with the data
  always_comb begin
    vld_nxt = {vld_r[4:1], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      vld_r        <= vld_nxt;
      out_tvalid_r <= vld_r[5];
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]      <= d_nxt[i];
        dsq_r[i]    <= dsq_nxt[i];
        proj_r[i]   <= proj_nxt[i];
        for (int j = 0; j < 3; j++) begin
          prod_r[j][i] <= prod_nxt[j][i];
        end
      end
      len3_r       <= len3_nxt;

      depth_ok4_r  <= depth_ok_nxt;
      su_r         <= su_nxt;
      sr_r         <= sr_nxt;
      hh_r         <= hh_nxt;
      hl_r         <= hl_nxt;
      ll_r         <= ll_nxt;
      pu4_r        <= proj_r[1];
      pr4_r        <= proj_r[2];
      len4_r       <= len3_r;

      dist_u_r     <= dist_u_nxt;
      dist_r_r     <= dist_r_nxt;
      lhs_r        <= lhs_nxt;
      rhs_r        <= rhs_nxt;
      depth_ok5_r  <= depth_ok4_r;
      pu5_r        <= pu4_r;
      pr5_r        <= pr4_r;

      in_frustum_r <= in_frustum_nxt;
      looked_at_r  <= looked_at_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(sfr_pkg::OUT_TDATA_W-2)'(0), looked_at_r, in_frustum_r};

endmodule

FILE: hdl/sfr_cfg.sv
// configuration register file with apb-style access
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfr_pkg::CFG_AW-1:0]   paddr,
  input  logic [sfr_pkg::CFG_DW-1:0]   pwdata,
  output logic [sfr_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output sfr_pkg::sfr_cfg_t            cfg
);

  sfr_pkg::sfr_cfg_t cfg_r;
  sfr_pkg::sfr_cfg_t cfg_nxt;
  sfr_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = sfr_pkg::reg_idx_t'(paddr[sfr_pkg::IDX_LSB +: sfr_pkg::IDX_W]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        sfr_pkg::REG_CAMERA: cfg_nxt.camera = pwdata[sfr_pkg::CAM_W-1:0];
        sfr_pkg::REG_FRONT:  cfg_nxt.front  = pwdata[sfr_pkg::AXREG_W-1:0];
        sfr_pkg::REG_UP:     cfg_nxt.up     = pwdata[sfr_pkg::AXREG_W-1:0];
        sfr_pkg::REG_RIGHT:  cfg_nxt.right  = pwdata[sfr_pkg::AXREG_W-1:0];
        sfr_pkg::REG_DEPTH:  cfg_nxt.depth  = pwdata[sfr_pkg::AXREG_W-1:0];
        sfr_pkg::REG_VCONE:  cfg_nxt.vcone  = pwdata[sfr_pkg::AXREG_W-1:0];
        sfr_pkg::REG_HCONE:  cfg_nxt.hcone  = pwdata[sfr_pkg::AXREG_W-1:0];
        sfr_pkg::REG_RSQ:    cfg_nxt.rsq    = pwdata[sfr_pkg::RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sfr_pkg::REG_CAMERA: prdata = sfr_pkg::CFG_DW'(cfg_r.camera);
      sfr_pkg::REG_FRONT:  prdata = sfr_pkg::CFG_DW'(cfg_r.front);
      sfr_pkg::REG_UP:     prdata = sfr_pkg::CFG_DW'(cfg_r.up);
      sfr_pkg::REG_RIGHT:  prdata = sfr_pkg::CFG_DW'(cfg_r.right);
      sfr_pkg::REG_DEPTH:  prdata = sfr_pkg::CFG_DW'(cfg_r.depth);
      sfr_pkg::REG_VCONE:  prdata = sfr_pkg::CFG_DW'(cfg_r.vcone);
      sfr_pkg::REG_HCONE:  prdata = sfr_pkg::CFG_DW'(cfg_r.hcone);
      sfr_pkg::REG_RSQ:    prdata = sfr_pkg::CFG_DW'(cfg_r.rsq);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.camera <= '0;
      cfg_r.front  <= sfr_pkg::FRONT_RST;
      cfg_r.up     <= sfr_pkg::UP_RST;
      cfg_r.right  <= sfr_pkg::RIGHT_RST;
      cfg_r.depth  <= '0;
      cfg_r.vcone  <= '0;
      cfg_r.hcone  <= '0;
      cfg_r.rsq    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/sfr_checker.sv
// port-level checks for the sphere test unit, bound to the top level
// depends on sfr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sfr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [sfr_pkg::CFG_AW-1:0]        cfg_paddr,
  input logic [sfr_pkg::CFG_DW-1:0]        cfg_pwdata,
  input logic [sfr_pkg::CFG_DW-1:0]        cfg_prdata,
  input logic                              cfg_pready
);

  // a stalled result beat holds
  `SFR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // input side only stalls when a result is stuck in the output register
  `SFR_ASSERT_ALWAYS(a_in_ready, in_tready == (!out_tvalid || out_tready), "input ready does not follow output slot")

  // pad bits above the two flags stay clear
  `SFR_ASSERT_ALWAYS(a_out_pad, !out_tvalid || out_tdata[sfr_pkg::OUT_TDATA_W-1:2] == '0, "result pad bits set")

  // a front axis write reads back on the next cycle at the same address
  `SFR_ASSERT_NEXT(a_cfg_readback, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr[sfr_pkg::IDX_LSB +: sfr_pkg::IDX_W] == sfr_pkg::REG_FRONT), cfg_pwrite || (cfg_paddr != $past(cfg_paddr)) || (cfg_prdata == {16'h0000, $past(cfg_pwdata[47:0])}), "front axis read back mismatch")

endmodule

bind sphere_frustum_and_ray_test_unit sfr_checker u_sfr_checker (.*);

FILE: verif/testbench.sv
// self-checking testbench for the sphere frustum cull and camera line test unit
// depends on sfr_pkg and sphere_frustum_and_ray_test_unit
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT   = 4000;   // cycles with no beat on any port
  localparam int PIPE_DRAIN   = 12;     // six-stage pipe plus slack
  localparam int RANDOM_VIEWS = 8;
  localparam int VIEW_BLOCKS  = 240;
  localparam int PROBE_X      = 256;    // camera of the plane and cone edge probes
  localparam int PROBE_Y      = 512;
  localparam int PROBE_Z      = -768;

  typedef struct packed {
    logic in_frustum;
    logic looked_at;
  } cull_flags_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                            in_tvalid;
  logic                            in_tready;
  // block_x [20:0], block_y [41:21], block_z [62:42]
  logic [sfr_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // in_frustum [0], looked_at [1]
  logic [sfr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [sfr_pkg::CFG_AW-1:0]      cfg_paddr;
  logic [sfr_pkg::CFG_DW-1:0]      cfg_pwdata;
  logic [sfr_pkg::CFG_DW-1:0]      cfg_prdata;
  logic                            cfg_pready;

  // register image as the unit should hold it
  sfr_pkg::sfr_cfg_t cfg_shadow;
  cull_flags_t       expected_flags[$];

  int  error_count  = 0;
  int  block_count  = 0;
  int  result_count = 0;
  int  write_count  = 0;
  int  idle_cycles  = 0;
  bit  no_idle      = 1'b0;

  // current aimed view: camera, which axis each basis vector lies on, its sign
  int view_cam[3];
  int view_front, view_up, view_right;
  int front_sgn, up_sgn, right_sgn;
  int view_radius;

  sphere_frustum_and_ray_test_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // projection of an offset onto a packed Q1.14 axis, exact Q.22
  function automatic longint project(longint d0, longint d1, longint d2,
                                     logic [sfr_pkg::AXREG_W-1:0] ax);
    return d0 * longint'($signed(ax[15:0])) + d1 * longint'($signed(ax[31:16]))
         + d2 * longint'($signed(ax[47:32]));
  endfunction

  // side test against one cone; a negative half width never passes
  function automatic bit cone_holds(longint p, longint depth8,
                                    logic [sfr_pkg::AXREG_W-1:0] cone);
    longint margin;
    longint slope;
    longint half_w;
    margin = longint'($signed(cone[23:0]));
    slope  = longint'($signed(cone[47:24]));
    half_w = margin * 16384 + depth8 * slope;
    return (-half_w <= p) && (p <= half_w);
  endfunction

  function automatic cull_flags_t predict_flags(input logic [sfr_pkg::POS_W-1:0] bx,
                                                input logic [sfr_pkg::POS_W-1:0] by,
                                                input logic [sfr_pkg::POS_W-1:0] bz);
    longint      d[3];
    longint      pf, pu, pr, depth8, near22, far22;
    logic [127:0] mag_f, front_sq, len_sq, mag_d;
    cull_flags_t r;
    d[0] = longint'($signed(bx)) - longint'($signed(cfg_shadow.camera[20:0]));
    d[1] = longint'($signed(by)) - longint'($signed(cfg_shadow.camera[41:21]));
    d[2] = longint'($signed(bz)) - longint'($signed(cfg_shadow.camera[62:42]));
    pf = project(d[0], d[1], d[2], cfg_shadow.front);
    pu = project(d[0], d[1], d[2], cfg_shadow.up);
    pr = project(d[0], d[1], d[2], cfg_shadow.right);
    near22 = longint'($signed(cfg_shadow.depth[23:0])) * 16384;
    far22  = longint'($signed(cfg_shadow.depth[47:24])) * 16384;
    depth8 = pf >>> 14;   // floor toward minus infinity
    r.in_frustum = (near22 <= pf) && (pf <= far22)
                && cone_holds(pu, depth8, cfg_shadow.vcone)
                && cone_holds(pr, depth8, cfg_shadow.hcone);
    // line test at Q.44: pf^2 + rsq*2^36 >= |d|^2 * 2^28
    mag_f    = (pf < 0) ? -pf : pf;
    front_sq = mag_f * mag_f + (128'(cfg_shadow.rsq) << 36);
    len_sq   = '0;
    for (int k = 0; k < 3; k++) begin
      mag_d  = (d[k] < 0) ? -d[k] : d[k];
      len_sq = len_sq + mag_d * mag_d;
    end
    r.looked_at = front_sq >= (len_sq << 28);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic send_block(input int bx, input int by, input int bz);
    int          gap;
    cull_flags_t want;
    gap  = no_idle ? 0 : $urandom_range(4);
    want = predict_flags(bx[sfr_pkg::POS_W-1:0], by[sfr_pkg::POS_W-1:0],
                         bz[sfr_pkg::POS_W-1:0]);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, bz[sfr_pkg::POS_W-1:0], by[sfr_pkg::POS_W-1:0],
                  bx[sfr_pkg::POS_W-1:0]};
    do @(posedge clk); while (!in_tready);
    expected_flags.push_back(want);
    block_count++;
  endtask

  // offset from the edge probe camera
  task automatic send_probe(input int dx, input int dy, input int dz);
    send_block(PROBE_X + dx, PROBE_Y + dy, PROBE_Z + dz);
  endtask

  // drop valid, let every pending result come back and the pipe run empty
  task automatic settle_pipe();
    in_tvalid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // setup phase, access phase until pready, then an idle step with psel low
  task automatic write_reg(input sfr_pkg::reg_idx_t idx,
                           input logic [sfr_pkg::CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    // the unit keeps only the register's own width
    case (idx)
      sfr_pkg::REG_CAMERA: cfg_shadow.camera = val[sfr_pkg::CAM_W-1:0];
      sfr_pkg::REG_FRONT:  cfg_shadow.front  = val[sfr_pkg::AXREG_W-1:0];
      sfr_pkg::REG_UP:     cfg_shadow.up     = val[sfr_pkg::AXREG_W-1:0];
      sfr_pkg::REG_RIGHT:  cfg_shadow.right  = val[sfr_pkg::AXREG_W-1:0];
      sfr_pkg::REG_DEPTH:  cfg_shadow.depth  = val[sfr_pkg::AXREG_W-1:0];
      sfr_pkg::REG_VCONE:  cfg_shadow.vcone  = val[sfr_pkg::AXREG_W-1:0];
      sfr_pkg::REG_HCONE:  cfg_shadow.hcone  = val[sfr_pkg::AXREG_W-1:0];
      sfr_pkg::REG_RSQ:    cfg_shadow.rsq    = val[sfr_pkg::RSQ_W-1:0];
      default: ;
    endcase
    write_count++;
  endtask

  task automatic program_view(input logic [sfr_pkg::CFG_DW-1:0] cam_word,
                              input logic [sfr_pkg::CFG_DW-1:0] front_word,
                              input logic [sfr_pkg::CFG_DW-1:0] up_word,
                              input logic [sfr_pkg::CFG_DW-1:0] right_word,
                              input logic [sfr_pkg::CFG_DW-1:0] depth_word,
                              input logic [sfr_pkg::CFG_DW-1:0] vcone_word,
                              input logic [sfr_pkg::CFG_DW-1:0] hcone_word,
                              input logic [sfr_pkg::CFG_DW-1:0] rsq_word);
    write_reg(sfr_pkg::REG_CAMERA, cam_word);
    write_reg(sfr_pkg::REG_FRONT,  front_word);
    write_reg(sfr_pkg::REG_UP,     up_word);
    write_reg(sfr_pkg::REG_RIGHT,  right_word);
    write_reg(sfr_pkg::REG_DEPTH,  depth_word);
    write_reg(sfr_pkg::REG_VCONE,  vcone_word);
    write_reg(sfr_pkg::REG_HCONE,  hcone_word);
    write_reg(sfr_pkg::REG_RSQ,    rsq_word);
  endtask

  function automatic logic [sfr_pkg::AXREG_W-1:0] unit_axis(int idx, int sgn);
    logic [sfr_pkg::AXREG_W-1:0] v;
    v = '0;
    v[idx * sfr_pkg::AXIS_W +: sfr_pkg::AXIS_W] = 16'(sgn * 16384);
    return v;
  endfunction

  function automatic int rand_sign();
    return ($urandom_range(1) == 1) ? 1 : -1;
  endfunction

  // axis-aligned camera with sensible planes, so blocks can be aimed at its cones
  task automatic set_aimed_view();
    int near_v, far_v, vmargin, hmargin, vslope, hslope, rsq_v;
    for (int k = 0; k < 3; k++) view_cam[k] = int'($urandom_range(524288)) - 262144;
    view_front  = $urandom_range(2);
    view_up     = (view_front + 1 + $urandom_range(1)) % 3;
    view_right  = 3 - view_front - view_up;
    front_sgn   = rand_sign();
    up_sgn      = rand_sign();
    right_sgn   = rand_sign();
    view_radius = $urandom_range(4096, 16);
    rsq_v   = (view_radius * view_radius) >> 8;
    near_v  = int'($urandom_range(4096)) - view_radius - 1024;
    far_v   = $urandom_range(131072, 16384);
    vmargin = view_radius + $urandom_range(view_radius / 2);
    hmargin = view_radius + $urandom_range(view_radius / 2);
    vslope  = $urandom_range(32768, 4096);
    hslope  = $urandom_range(32768, 4096);
    // now and then a cone of negative width
    if ($urandom_range(9) == 0) vmargin = -vmargin;
    if ($urandom_range(9) == 0) hslope = -hslope;
    program_view({1'($urandom), 21'(view_cam[2]), 21'(view_cam[1]), 21'(view_cam[0])},
                 {16'($urandom), unit_axis(view_front, front_sgn)},
                 {16'($urandom), unit_axis(view_up, up_sgn)},
                 {16'($urandom), unit_axis(view_right, right_sgn)},
                 {16'd0, 24'(far_v), 24'(near_v)},
                 {16'd0, 24'(vslope), 24'(vmargin)},
                 {16'd0, 24'(hslope), 24'(hmargin)},
                 {40'($urandom), 24'(rsq_v)});
  endtask

  // block along the view axis with side offsets around the sphere and cone widths
  task automatic send_aimed_block();
    int along, span, pu, pr;
    int ofs[3];
    along = int'($urandom_range(147456)) - 16384;
    span  = (along < 0 ? -along : along) / 2 + 2 * view_radius + 16;
    pu    = int'($urandom_range(2 * span)) - span;
    pr    = int'($urandom_range(2 * span)) - span;
    ofs   = '{0, 0, 0};
    ofs[view_front] += front_sgn * along;
    ofs[view_up]    += up_sgn * pu;
    ofs[view_right] += right_sgn * pr;
    send_block(view_cam[0] + ofs[0], view_cam[1] + ofs[1], view_cam[2] + ofs[2]);
  endtask

  function automatic int corner_coord(int cam);
    case ($urandom_range(3))
      0:       return -1048576;
      1:       return 1048575;
      2:       return 0;
      default: return cam;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset planes are all zero: only a block exactly at the camera is inside
  task automatic test_reset_values();
    send_block(0, 0, 0);
    send_block(256, -256, 512);
  endtask

  // all-ones words (bits above each register masked off) and mixed field extremes
  task automatic test_register_extremes();
    settle_pipe();
    program_view('1, '1, '1, '1, '1, '1, '1, '1);
    send_block(1048575, 1048575, 1048575);
    send_block(-1048576, -1048576, -1048576);
    send_block(-1048576, 1048575, 0);
    send_block(0, 0, 0);
    settle_pipe();
    program_view({1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF},
                 {16'd0, 16'h7FFF, 16'h8000, 16'h7FFF},
                 {16'd0, 16'h8000, 16'h8000, 16'h8000},
                 {16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF},
                 {16'd0, 24'h7FFFFF, 24'h800000},
                 {16'd0, 24'h7FFFFF, 24'h7FFFFF},
                 {16'd0, 24'h800000, 24'h000000},
                 {40'd0, 24'hFFFFFF});
    send_block(1048575, 1048575, 1048575);
    send_block(-1048576, -1048576, -1048576);
    send_block(-1048576, 1048575, 0);
    send_block(0, 0, 0);
  endtask

  // exact hits on near, far, cone edges and a tangent line, plus one past each
  task automatic test_view_edges();
    settle_pipe();
    // near 2.0, far 100.0, vertical margin 2.0 slope 0, horizontal margin 2.0 slope 1, r 2.0
    program_view({1'b0, 21'(PROBE_Z), 21'(PROBE_Y), 21'(PROBE_X)},
                 sfr_pkg::FRONT_RST, sfr_pkg::UP_RST, sfr_pkg::RIGHT_RST,
                 {16'd0, 24'd25600, 24'd512},
                 {16'd0, 24'd0, 24'd512},
                 {16'd0, 24'd16384, 24'd512},
                 64'd1024);
    send_probe(1024, 0, 0);
    send_probe(-1024, 0, 0);      // behind: culled but still on the line
    send_probe(512, 0, 0);
    send_probe(511, 0, 0);
    send_probe(25600, 0, 0);
    send_probe(25601, 0, 0);
    send_probe(1024, 512, 0);     // on the cone and tangent to the line
    send_probe(1024, 513, 0);
    send_probe(1024, 0, 1536);
    send_probe(1024, 0, 1537);
    send_probe(1024, 0, -1536);
    // negative cone width fails even with the block on the axis
    settle_pipe();
    write_reg(sfr_pkg::REG_VCONE, 64'h00FF_FFFF);
    send_probe(1024, 0, 0);
    // zero width only passes a zero projection
    settle_pipe();
    write_reg(sfr_pkg::REG_VCONE, 64'd0);
    send_probe(1024, 0, 0);
    send_probe(1024, 1, 0);
    // front axis far from unit length is taken as given
    settle_pipe();
    write_reg(sfr_pkg::REG_FRONT, {16'd0, 16'(-20000), 16'd5000, 16'd32767});
    send_probe(3000, -2000, 700);
  endtask

  // mostly blocks aimed at an axis-aligned view, with noise and corner values;
  // every fourth view loads random words into all registers
  task automatic test_random_views();
    int pick;
    for (int view = 0; view < RANDOM_VIEWS; view++) begin
      settle_pipe();
      if (view % 4 == 3) begin
        program_view({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        set_aimed_view();
      end
      for (int n = 0; n < VIEW_BLOCKS; n++) begin
        // stretches of back-to-back beats on both sides
        no_idle = ((n / 40) % 3 == 1);
        pick    = $urandom_range(19);
        if (pick < 14) begin
          send_aimed_block();
        end else if (pick < 17) begin
          send_block($urandom, $urandom, $urandom);
        end else begin
          send_block(corner_coord(view_cam[0]), corner_coord(view_cam[1]),
                     corner_coord(view_cam[2]));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall per beat, compare against the oldest prediction
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : check_result
    cull_flags_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_flags.size() == 0) begin
        $error("result beat 0x%0h with no block pending", out_tdata);
        error_count++;
      end else begin
        want = expected_flags.pop_front();
        if (out_tdata[0] !== want.in_frustum) begin
          $error("in_frustum: expected %0b, got %0b", want.in_frustum, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[1] !== want.looked_at) begin
          $error("looked_at: expected %0b, got %0b", want.looked_at, out_tdata[1]);
          error_count++;
        end
        result_count++;
      end
    end
  end

  // watchdog: any stream beat or register write restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)
          || (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_flags.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cfg_shadow  = '{camera: '0, front: sfr_pkg::FRONT_RST, up: sfr_pkg::UP_RST,
                    right: sfr_pkg::RIGHT_RST, depth: '0, vcone: '0, hcone: '0,
                    rsq: '0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_register_extremes();
    test_view_edges();
    test_random_views();
    settle_pipe();

    $display("checked %0d result beats for %0d block beats, %0d register writes",
             result_count, block_count, write_count);
    $display("covered reset values, register extremes, plane and cone edges, %0d views",
             RANDOM_VIEWS);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
